// File: sv/iptp_pkg.sv
// Package for the IP address text parser: types, codes and widths.
// Used by every module of the block; depends on nothing.
package iptp_pkg;
	localparam int NumGroups = 8;
	localparam int PrefixLen = 7;

	typedef enum logic [1:0] {
		FAM_V4  = 2'd0,
		FAM_V6  = 2'd1,
		FAM_UNS = 2'd2,
		FAM_RSV = 2'd3
	} family_t;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNSUPP  = 2'd2,
		ST_SPARE   = 2'd3
	} status_t;

	// Character classes found by the front part.
	typedef enum logic [2:0] {
		CL_DEC   = 3'd0,
		CL_HEXAL = 3'd1,
		CL_DOT   = 3'd2,
		CL_COLON = 3'd3,
		CL_END   = 3'd4,
		CL_OTHER = 3'd5
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic [7:0] ch;
		logic [1:0] family;
		logic       first;
	} tok_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		case (i)
			3'd0, 3'd1, 3'd6: prefix_char = 8'h3a;
			3'd2, 3'd3, 3'd4, 3'd5: prefix_char = 8'h66;
			default: prefix_char = 8'h00;
		endcase
	endfunction
endpackage

// File: sv/iptp_front.sv
// Front part: accepts characters, classifies them and tracks string starts.
// Depends on iptp_pkg.
module iptp_front import iptp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      family,
	input  logic [7:0]      ch,
	output logic            tok_valid,
	input  logic            tok_ready,
	output tok_t            tok
);
	logic at_start_q;
	cls_t cls;
	logic [3:0] dig;

	always_comb begin
		cls = CL_OTHER;
		dig = 4'd0;
		if (ch == 8'd0) begin
			cls = CL_END;
		end else if (ch inside {[8'h30:8'h39]}) begin
			cls = CL_DEC;
			dig = 4'(ch - 8'h30);
		end else if (ch inside {[8'h61:8'h66]}) begin
			cls = CL_HEXAL;
			dig = 4'(ch - 8'h57);
		end else if (ch inside {[8'h41:8'h46]}) begin
			cls = CL_HEXAL;
			dig = 4'(ch - 8'h37);
		end else if (ch == 8'h2e) begin
			cls = CL_DOT;
		end else if (ch == 8'h3a) begin
			cls = CL_COLON;
		end
	end

	assign tok_valid = in_valid;
	assign in_ready  = tok_ready;
	assign tok = '{cls: cls, digit: dig, ch: ch, family: family, first: at_start_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (in_valid && tok_ready) begin
			at_start_q <= (cls == CL_END);
		end
	end
endmodule

// File: sv/iptp_fifo.sv
// Short queue of classified characters between the front and back parts.
// Depends on iptp_pkg.
module iptp_fifo import iptp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  tok_t wr_tok,
	output logic rd_valid,
	input  logic rd_ready,
	output tok_t rd_tok
);
	tok_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_tok   = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
		end
	end
endmodule

// File: sv/iptp_back.sv
// Back part: parses IPv4 and IPv6 text and builds the result register.
// Depends on iptp_pkg.
module iptp_back import iptp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         tok_valid,
	output logic         tok_ready,
	input  tok_t         tok,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [1:0]   status,
	output logic [63:0]  addr_hi,
	output logic [63:0]  addr_lo
);
	logic [1:0]  fam_q;
	logic        failed_q, mapped_q, gap_q, dseen_q;
	logic [2:0]  pm_q;
	logic [15:0] grp_q [NumGroups];
	logic [3:0]  gcnt_q, gpos_q;
	logic [15:0] fval_q;
	logic [1:0]  colon_q;
	logic [7:0]  oct_q [3];
	logic [2:0]  oidx_q;
	logic        ovalid_q;
	logic [1:0]  ostat_q;
	logic [63:0] ohi_q, olo_q;

	// Working copies, cleared at string start.
	logic [1:0]  fam;
	logic        failed, mapped, gap, dseen;
	logic [2:0]  pm;
	logic [15:0] grp [NumGroups];
	logic [3:0]  gcnt, gpos;
	logic [15:0] fval;
	logic [1:0]  colon;
	logic [7:0]  oct [3];
	logic [2:0]  oidx;
	logic [1:0]  rstat;
	logic [63:0] rhi, rlo;
	logic [19:0] nv;
	logic        take, is_hex, v4mode, v6ok, cg;
	logic [3:0]  z;
	logic [2:0]  ksrc;
	logic [15:0] g;
	logic [127:0] full;

	assign take = tok_valid && tok_ready;
	assign tok_ready = !ovalid_q || out_ready;
	assign out_valid = ovalid_q;
	assign status = ostat_q;
	assign addr_hi = ohi_q;
	assign addr_lo = olo_q;

	always_comb begin
		fam = fam_q; failed = failed_q; mapped = mapped_q; gap = gap_q;
		dseen = dseen_q; pm = pm_q; grp = grp_q; gcnt = gcnt_q; gpos = gpos_q;
		fval = fval_q; colon = colon_q; oct = oct_q; oidx = oidx_q;
		rstat = ST_INVALID; rhi = '0; rlo = '0; nv = '0; v6ok = 1'b0; cg = 1'b0;
		z = '0; ksrc = '0; g = '0; full = '0;
		is_hex = (tok.cls == CL_DEC) || (tok.cls == CL_HEXAL);
		if (tok.first) begin
			fam = tok.family; failed = 1'b0; mapped = 1'b0; gap = 1'b0;
			dseen = 1'b0; pm = '0; gcnt = '0; gpos = '0; fval = '0;
			colon = '0; oidx = '0;
			for (int i = 0; i < NumGroups; i++) grp[i] = '0;
			for (int i = 0; i < 3; i++) oct[i] = '0;
		end
		v4mode = (fam == FAM_V4) || (fam == FAM_V6 && mapped);
		if (tok.cls != CL_END) begin
			if (!failed && (fam == FAM_V4 || fam == FAM_V6)) begin
				if (v4mode) begin
					if (tok.cls == CL_DEC) begin
						nv = 20'({fval, 3'b0}) + 20'({fval, 1'b0}) + 20'(tok.digit);
						if (nv > 20'd255) failed = 1'b1;
						else begin fval = nv[15:0]; dseen = 1'b1; end
					end else if (tok.cls == CL_DOT) begin
						if (!dseen || oidx >= 3'd3) failed = 1'b1;
						else begin
							oct[oidx[1:0]] = fval[7:0];
							oidx = 3'(oidx + 3'd1); fval = '0; dseen = 1'b0;
						end
					end else failed = 1'b1;
				end else begin
					if (is_hex) begin
						if (colon == 2'd1 && gcnt == 4'd0 && !gap) failed = 1'b1;
						else if (fval[15:12] != 4'd0) failed = 1'b1;
						else begin
							fval = {fval[11:0], tok.digit}; dseen = 1'b1; colon = 2'd0;
						end
					end else if (tok.cls == CL_COLON) begin
						if (colon == 2'd0) begin
							if (dseen) begin
								if (gcnt >= 4'd8) failed = 1'b1;
								else begin
									grp[gcnt[2:0]] = fval; gcnt = 4'(gcnt + 4'd1);
									fval = '0; dseen = 1'b0;
								end
							end
							if (!failed) colon = 2'd1;
						end else if (colon == 2'd1) begin
							if (gap) failed = 1'b1;
							else begin gap = 1'b1; gpos = gcnt; colon = 2'd2; end
						end else failed = 1'b1;
					end else failed = 1'b1;
					if (!failed && pm < 3'(PrefixLen)) begin
						if (tok.ch == prefix_char(pm)) begin
							pm = 3'(pm + 3'd1);
							if (pm == 3'(PrefixLen)) begin
								mapped = 1'b1; fval = '0; dseen = 1'b0; oidx = '0;
							end
						end else pm = 3'(PrefixLen);
					end
				end
			end
		end else begin
			if (fam == FAM_UNS || fam == FAM_RSV) rstat = ST_UNSUPP;
			else if (v4mode) begin
				if (!failed && dseen && oidx == 3'd3) begin
					rstat = ST_VALID;
					rlo = {16'd0, mapped ? 16'hffff : 16'd0,
						oct[0], oct[1], oct[2], fval[7:0]};
				end
			end else begin
				v6ok = !failed && colon != 2'd1;
				cg = v6ok && colon == 2'd0 && dseen;
				if (cg) begin
					if (gcnt >= 4'd8) v6ok = 1'b0;
					else begin grp[gcnt[2:0]] = fval; gcnt = 4'(gcnt + 4'd1); end
				end
				if (v6ok && !gap && gcnt != 4'd8) v6ok = 1'b0;
				if (v6ok) begin
					rstat = ST_VALID;
					z = 4'(4'd8 - gcnt);
					for (int k = 0; k < NumGroups; k++) begin
						ksrc = 3'(4'(k) - z);
						if (!gap || 4'(k) < gpos) g = grp[k];
						else if (5'(k) < 5'(gpos) + 5'(z)) g = '0;
						else g = grp[ksrc];
						full[127 - 16*k -: 16] = g;
					end
					rhi = full[127:64];
					rlo = full[63:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fam_q <= '0; failed_q <= 1'b0; mapped_q <= 1'b0; gap_q <= 1'b0;
			dseen_q <= 1'b0; pm_q <= '0; gcnt_q <= '0; gpos_q <= '0;
			fval_q <= '0; colon_q <= '0; oidx_q <= '0; ovalid_q <= 1'b0;
		end else begin
			ovalid_q <= (ovalid_q && !out_ready) || (take && tok.cls == CL_END);
			if (take) begin
				fam_q <= fam; failed_q <= failed; mapped_q <= mapped; gap_q <= gap;
				dseen_q <= dseen; pm_q <= pm; gcnt_q <= gcnt; gpos_q <= gpos;
				fval_q <= fval; colon_q <= colon; oidx_q <= oidx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_q <= grp;
			oct_q <= oct;
			if (tok.cls == CL_END) begin
				ostat_q <= rstat; ohi_q <= rhi; olo_q <= rlo;
			end
		end
	end
endmodule

// File: sv/ip_address_text_parser.sv
// IP address text parser: one character per request, one result per string.
// Throughput: one character per cycle, back to back, while no result waits. The
// result is registered: its zero byte is written into the two-entry queue, and
// the back part then takes it from there into its result register.
// A waiting result holds the back part; the queue then fills and stalls input.
// Reset (arst_n, asynchronous) empties the queue and starts a new string.
module ip_address_text_parser import iptp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] ch
	input  logic [1:0]   s_axis_tuser,  // [1:0] family
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata   // [1:0] status, [65:2] addr_hi, [129:66] addr_lo
);
	logic fv, fr, bv, br;
	tok_t ft, bt;
	logic [1:0] st;
	logic [63:0] hi, lo;

	iptp_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.family(s_axis_tuser), .ch(s_axis_tdata), .tok_valid(fv), .tok_ready(fr), .tok(ft));
	iptp_fifo u_fifo (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_tok(ft),
		.rd_valid(bv), .rd_ready(br), .rd_tok(bt));
	iptp_back u_back (.clk, .arst_n, .tok_valid(bv), .tok_ready(br), .tok(bt),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .status(st),
		.addr_hi(hi), .addr_lo(lo));

	assign m_axis_tdata = {6'd0, lo, hi, st};
endmodule
